FILE: rtl/tsmc_pkg.sv
// ----------------------------------------------------------------------------
// tsmc_pkg: shared types and constants of the tile sign-mix classifier
// Codes for registers, signs and classes, and the structs that travel
// between the front end, the tile queue and the back end.
// ----------------------------------------------------------------------------
package tsmc_pkg;

  // Fixed field widths
  localparam int unsigned CountW = 14;   // column / row counters
  localparam int unsigned DimW   = 15;   // grid width / height
  localparam int unsigned TsW    = 7;    // tile size
  localparam int unsigned IdxW   = 2;    // configuration register index
  localparam int unsigned ColW   = 8;    // tile_col result field

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_TILE_SIZE   = 2'd0;
  localparam logic [IdxW-1:0] REG_GRID_WIDTH  = 2'd1;
  localparam logic [IdxW-1:0] REG_GRID_HEIGHT = 2'd2;

  // Limits of the grid registers
  localparam logic [DimW-1:0] GRID_LIMIT = 15'd16384;

  // Three-valued sign codes
  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG  = 2'b11;

  // Tile class codes
  localparam logic signed [1:0] CLASS_ZERO  = 2'sb00;
  localparam logic signed [1:0] CLASS_POS   = 2'sb01;
  localparam logic signed [1:0] CLASS_MIXED = 2'sb11;

  // Divider steps for the tile position resync (one quotient bit a step)
  localparam logic [3:0] DIV_LAST = 4'd13;

  typedef enum logic {
    RS_RUN,
    RS_DIV
  } resync_state_e;

  // Control part of one queued sample
  typedef struct packed {
    logic              first;
    logic              last;
    logic [CountW-1:0] tr;
    logic [CountW-1:0] tc;
  } item_ctl_t;

  // One result transaction
  typedef struct packed {
    logic [CountW-1:0] tile_row;
    logic [ColW-1:0]   tile_col;
    logic signed [1:0] tile_class;
  } res_t;

endpackage

FILE: rtl/tsmc_fifo.sv
// ----------------------------------------------------------------------------
// tsmc_fifo: short synchronous queue
// Register-based first-in first-out store with push/full and pop/empty.
// ----------------------------------------------------------------------------
module tsmc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/tsmc_front.sv
// ----------------------------------------------------------------------------
// tsmc_front: sample intake and tile classification
// Holds the configuration, tracks column/row and tile position of each
// sample, drops those outside whole tiles or tracked columns, queues the rest.
// ----------------------------------------------------------------------------
module tsmc_front #(
  parameter int unsigned MAX_TILES_ACROSS = 256,
  parameter int unsigned SAMPLE_BITS      = 32,
  parameter int unsigned MAX_TILE         = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tsmc_pkg::IdxW-1:0]    cfg_idx_i,
  input  logic [tsmc_pkg::DimW-1:0]    cfg_wdata_i,
  input  logic                         push_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                         full_o,
  input  logic                         mid_full_i,
  output logic                         mid_push_o,
  output tsmc_pkg::item_ctl_t          mid_ctl_o,
  output logic [SAMPLE_BITS-1:0]       mid_sample_o
);

  import tsmc_pkg::*;

  resync_state_e   st_q, st_d;
  logic [3:0]      step_q, step_d;
  logic [TsW-1:0]  ts_q;
  logic [DimW-1:0] w_q, h_q;
  logic [CountW-1:0] c_q, c_d, r_q, r_d, tc_q, tc_d, tr_q, tr_d;
  logic [TsW-1:0]  bc_q, bc_d, br_q, br_d;
  logic            ts_write, accept, keep;
  logic            in_grid, col_ok, row_ok, tc_ok;
  logic [DimW-1:0] col_end, row_end;
  logic [TsW-1:0]  ts_new;

  // Clamp a grid dimension to 1..GRID_LIMIT
  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v);
    logic [DimW-1:0] res;
    res = v;
    if (v == '0) begin
      res = DimW'(1);
    end else if (v > GRID_LIMIT) begin
      res = GRID_LIMIT;
    end
    return res;
  endfunction

  // One restoring-division step: remainder in rem, dividend/quotient in quo
  function automatic logic [TsW+CountW-1:0] div_step(logic [TsW-1:0] rem,
                                                      logic [CountW-1:0] quo,
                                                      logic [TsW-1:0] d);
    logic [TsW:0]   trial;
    logic [TsW-1:0] rem_n;
    logic           qbit;
    trial = {rem, quo[CountW-1]};
    qbit  = (trial >= {1'b0, d});
    rem_n = qbit ? TsW'(trial - {1'b0, d}) : TsW'(trial);
    return {rem_n, quo[CountW-2:0], qbit};
  endfunction

  assign ts_write = cfg_we_i && (cfg_idx_i == REG_TILE_SIZE);
  assign full_o   = (st_q != RS_RUN) || mid_full_i;
  assign accept   = push_i && !full_o;

  // Clamp tile size to 1..MAX_TILE
  always_comb begin
    ts_new = cfg_wdata_i[TsW-1:0];
    if (ts_new == '0) begin
      ts_new = TsW'(1);
    end else if ({2'b00, ts_new} > 9'(MAX_TILE)) begin
      ts_new = TsW'(MAX_TILE);
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= TsW'(8);
      w_q  <= DimW'(1024);
      h_q  <= DimW'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TILE_SIZE:   ts_q <= ts_new;
        REG_GRID_WIDTH:  w_q  <= clamp_dim(cfg_wdata_i);
        REG_GRID_HEIGHT: h_q  <= clamp_dim(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Classify the current sample
  assign col_end = {1'b0, c_q} - DimW'(bc_q) + DimW'(ts_q);
  assign row_end = {1'b0, r_q} - DimW'(br_q) + DimW'(ts_q);
  assign in_grid = ({1'b0, c_q} < w_q) && ({1'b0, r_q} < h_q);
  assign col_ok  = (col_end <= w_q);
  assign row_ok  = (row_end <= h_q);
  assign tc_ok   = ({1'b0, tc_q} < DimW'(MAX_TILES_ACROSS));
  assign keep    = in_grid && col_ok && row_ok && tc_ok;

  assign mid_push_o      = accept && keep;
  assign mid_ctl_o.first = (bc_q == '0) && (br_q == '0);
  assign mid_ctl_o.last  = ((TsW+1)'(bc_q) + 1'b1 == {1'b0, ts_q}) &&
                           ((TsW+1)'(br_q) + 1'b1 == {1'b0, ts_q});
  assign mid_ctl_o.tr    = tr_q;
  assign mid_ctl_o.tc    = tc_q;
  assign mid_sample_o    = sample_i;

  // Next counters: resync after a tile size write, else advance per sample
  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    c_d    = c_q;
    r_d    = r_q;
    tc_d   = tc_q;
    tr_d   = tr_q;
    bc_d   = bc_q;
    br_d   = br_q;
    if (ts_write) begin
      st_d   = RS_DIV;
      step_d = '0;
      tc_d   = c_q;
      bc_d   = '0;
      tr_d   = r_q;
      br_d   = '0;
    end else begin
      unique case (st_q)
        RS_DIV: begin
          {bc_d, tc_d} = div_step(bc_q, tc_q, ts_q);
          {br_d, tr_d} = div_step(br_q, tr_q, ts_q);
          step_d = step_q + 1'b1;
          if (step_q == DIV_LAST) begin
            st_d = RS_RUN;
          end
        end
        RS_RUN: begin
          if (accept) begin
            if ({1'b0, c_q} + DimW'(1) >= w_q) begin
              c_d  = '0;
              tc_d = '0;
              bc_d = '0;
              if ({1'b0, r_q} + DimW'(1) >= h_q) begin
                r_d  = '0;
                tr_d = '0;
                br_d = '0;
              end else begin
                r_d = r_q + 1'b1;
                if ((TsW+1)'(br_q) + 1'b1 == {1'b0, ts_q}) begin
                  br_d = '0;
                  tr_d = tr_q + 1'b1;
                end else begin
                  br_d = br_q + 1'b1;
                end
              end
            end else begin
              c_d = c_q + 1'b1;
              if ((TsW+1)'(bc_q) + 1'b1 == {1'b0, ts_q}) begin
                bc_d = '0;
                tc_d = tc_q + 1'b1;
              end else begin
                bc_d = bc_q + 1'b1;
              end
            end
          end
        end
        default: st_d = RS_RUN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= RS_RUN;
      step_q <= '0;
      c_q    <= '0;
      r_q    <= '0;
      tc_q   <= '0;
      tr_q   <= '0;
      bc_q   <= '0;
      br_q   <= '0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
      c_q    <= c_d;
      r_q    <= r_d;
      tc_q   <= tc_d;
      tr_q   <= tr_d;
      bc_q   <= bc_d;
      br_q   <= br_d;
    end
  end

endmodule

FILE: rtl/tsmc_back.sv
// ----------------------------------------------------------------------------
// tsmc_back: per-tile accumulation and result generation
// Keeps reference sign, mix flag and running sum per tile column in a
// memory, updates the entry for each queued sample and emits the class.
// ----------------------------------------------------------------------------
module tsmc_back #(
  parameter int unsigned MAX_TILES_ACROSS = 256,
  parameter int unsigned SAMPLE_BITS      = 32,
  parameter int unsigned MAX_TILE         = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     mid_empty_i,
  input  tsmc_pkg::item_ctl_t      mid_ctl_i,
  input  logic [SAMPLE_BITS-1:0]   mid_sample_i,
  output logic                     mid_pop_o,
  input  logic                     res_full_i,
  output logic                     res_push_o,
  output tsmc_pkg::res_t           res_o
);

  import tsmc_pkg::*;

  localparam int unsigned SumBits = SAMPLE_BITS + 2 * $clog2(MAX_TILE) + 1;
  localparam int unsigned EntW    = SumBits + 3;
  localparam int unsigned TcBits  = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;

  logic [EntW-1:0]        ent_mem [MAX_TILES_ACROSS];
  logic [EntW-1:0]        rd_q;
  logic                   s1_v_q;
  item_ctl_t              s1_ctl_q;
  logic [SAMPLE_BITS-1:0] s1_smp_q;
  logic                   byp_v_q;
  logic [TcBits-1:0]      byp_idx_q;
  logic [EntW-1:0]        byp_q;

  logic                   adv, take;
  logic [TcBits-1:0]      s1_idx, in_idx;
  logic [EntW-1:0]        old_ent, new_ent;
  logic [1:0]             old_sign, sg;
  logic                   old_mix, new_mix;
  logic [SumBits-1:0]     old_sum, new_sum, smp_ext;
  logic signed [1:0]      res_class;

  assign in_idx = mid_ctl_i.tc[TcBits-1:0];
  assign s1_idx = s1_ctl_q.tc[TcBits-1:0];

  // Advance the stage unless a result has nowhere to go
  assign adv       = s1_v_q && (!s1_ctl_q.last || !res_full_i);
  assign take      = !mid_empty_i && (!s1_v_q || adv);
  assign mid_pop_o = take;

  // Forward the last write when it hits the same tile column
  assign old_ent  = (byp_v_q && (byp_idx_q == s1_idx)) ? byp_q : rd_q;
  assign old_sign = old_ent[EntW-1 -: 2];
  assign old_mix  = old_ent[SumBits];
  assign old_sum  = old_ent[SumBits-1:0];

  // Sign and extension of the sample
  assign smp_ext = {{(SumBits-SAMPLE_BITS){s1_smp_q[SAMPLE_BITS-1]}}, s1_smp_q};
  always_comb begin
    if (s1_smp_q == '0) begin
      sg = SIGN_ZERO;
    end else if (s1_smp_q[SAMPLE_BITS-1]) begin
      sg = SIGN_NEG;
    end else begin
      sg = SIGN_POS;
    end
  end

  // Start or update the tile entry
  always_comb begin
    if (s1_ctl_q.first) begin
      new_mix = 1'b0;
      new_sum = smp_ext;
      new_ent = {sg, 1'b0, smp_ext};
    end else begin
      new_mix = old_mix || (sg != old_sign);
      new_sum = old_sum + smp_ext;
      new_ent = {old_sign, new_mix, new_sum};
    end
  end

  // Classify the completed tile
  assign res_push_o       = adv && s1_ctl_q.last;
  assign res_o.tile_row   = s1_ctl_q.tr;
  assign res_o.tile_col   = s1_ctl_q.tc[ColW-1:0];
  assign res_o.tile_class = res_class;
  always_comb begin
    if (new_mix) begin
      res_class = CLASS_MIXED;
    end else if ((new_sum != '0) && !new_sum[SumBits-1]) begin
      res_class = CLASS_POS;
    end else begin
      res_class = CLASS_ZERO;
    end
  end

  // Tile memory: read on take, write on advance
  always_ff @(posedge clk_i) begin
    if (take) begin
      rd_q <= ent_mem[in_idx];
    end
    if (adv) begin
      ent_mem[s1_idx] <= new_ent;
    end
  end

  // Stage and bypass control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      byp_v_q <= 1'b0;
    end else begin
      if (take) begin
        s1_v_q <= 1'b1;
      end else if (adv) begin
        s1_v_q <= 1'b0;
      end
      if (adv) begin
        byp_v_q <= 1'b1;
      end
    end
  end

  // Stage and bypass payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_ctl_q <= mid_ctl_i;
      s1_smp_q <= mid_sample_i;
    end
    if (adv) begin
      byp_idx_q <= s1_idx;
      byp_q     <= new_ent;
    end
  end

endmodule

FILE: rtl/tile_sign_mix_classifier.sv
// ----------------------------------------------------------------------------
// tile_sign_mix_classifier: tile sign-mix classifier, top level
// Raster samples in, one class per completed square tile out.
//
//   channel   | direction | handshake             | payload
//   ----------+-----------+-----------------------+--------------------------
//   sample    | in        | push / full           | sample_i
//   result    | out       | pop / empty           | tile_row_o, tile_col_o,
//             |           |                       | tile_class_o
//   config    | in        | cfg_we_i (no wait)    | cfg_idx_i, cfg_wdata_i
//
// One sample per cycle sustained while full stays low; a result passes the
// tile queue, the memory read stage and the result queue before it reaches
// the output ports; the front adds no register.
// Reset clears counters and queues; the tile memory holds no reset value.
// A tile size write runs a position resync during which full is high.
// A full result queue stalls the back end; the tile queue absorbs it first.
// ----------------------------------------------------------------------------
module tile_sign_mix_classifier #(
  parameter int unsigned MAX_TILES_ACROSS = 256,
  parameter int unsigned SAMPLE_BITS      = 32,
  parameter int unsigned MAX_TILE         = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsmc_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [tsmc_pkg::DimW-1:0]     cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          pop,
  output logic                          empty,
  output logic [tsmc_pkg::CountW-1:0]   tile_row_o,
  output logic [tsmc_pkg::ColW-1:0]     tile_col_o,
  output logic signed [1:0]             tile_class_o
);

  import tsmc_pkg::*;

  localparam int unsigned MidW = $bits(item_ctl_t) + SAMPLE_BITS;
  localparam int unsigned ResW = $bits(res_t);

  logic                   mid_push, mid_full, mid_pop, mid_empty;
  item_ctl_t              front_ctl, mid_ctl;
  logic [SAMPLE_BITS-1:0] front_smp, mid_smp;
  logic [MidW-1:0]        mid_rdata;
  logic                   res_push, res_full;
  res_t                   back_res, out_res;
  logic [ResW-1:0]        res_rdata;

  // Intake and classification
  tsmc_front #(
    .MAX_TILES_ACROSS (MAX_TILES_ACROSS),
    .SAMPLE_BITS      (SAMPLE_BITS),
    .MAX_TILE         (MAX_TILE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_i       (push),
    .sample_i     (sample_i),
    .full_o       (full),
    .mid_full_i   (mid_full),
    .mid_push_o   (mid_push),
    .mid_ctl_o    (front_ctl),
    .mid_sample_o (front_smp)
  );

  // Queue between front and back
  tsmc_fifo #(
    .WIDTH (MidW),
    .DEPTH (4)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i ({front_ctl, front_smp}),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  assign mid_ctl = mid_rdata[MidW-1:SAMPLE_BITS];
  assign mid_smp = mid_rdata[SAMPLE_BITS-1:0];

  // Tile accumulation
  tsmc_back #(
    .MAX_TILES_ACROSS (MAX_TILES_ACROSS),
    .SAMPLE_BITS      (SAMPLE_BITS),
    .MAX_TILE         (MAX_TILE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mid_empty_i  (mid_empty),
    .mid_ctl_i    (mid_ctl),
    .mid_sample_i (mid_smp),
    .mid_pop_o    (mid_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (back_res)
  );

  // Result queue
  tsmc_fifo #(
    .WIDTH (ResW),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign out_res      = res_rdata;
  assign tile_row_o   = out_res.tile_row;
  assign tile_col_o   = out_res.tile_col;
  assign tile_class_o = out_res.tile_class;

endmodule

FILE: verif/tile_sign_mix_classifier_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_sign_mix_classifier_checker: result checker of the tile classifier
// Watches the register port and both queue channels, tracks the raster
// position and the per-column tile state itself, and compares every popped
// result with the oldest predicted tile class.
// ----------------------------------------------------------------------------
module tile_sign_mix_classifier_checker #(
  parameter int unsigned MAX_TILES_ACROSS = 256,
  parameter int unsigned SAMPLE_BITS      = 32,
  parameter int unsigned MAX_TILE         = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsmc_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [tsmc_pkg::DimW-1:0]     cfg_wdata_i,
  input  logic                          push_i,
  input  logic                          full_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          pop_i,
  input  logic                          empty_i,
  input  logic [tsmc_pkg::CountW-1:0]   tile_row_i,
  input  logic [tsmc_pkg::ColW-1:0]     tile_col_i,
  input  logic signed [1:0]             tile_class_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import tsmc_pkg::*;

  localparam int unsigned GridMax = 16384;

  // Register copies
  logic [TsW-1:0]  cfg_tile;
  logic [DimW-1:0] cfg_width;
  logic [DimW-1:0] cfg_height;

  // Raster position and per-column tile state
  int unsigned             col_pos;
  int unsigned             row_pos;
  logic [1:0]              sign_ref [MAX_TILES_ACROSS];
  logic                    mix_seen [MAX_TILES_ACROSS];
  longint                  sum_acc  [MAX_TILES_ACROSS];

  res_t tile_results_q[$];
  int   n_fail;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic log_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    n_fail++;
  endtask

  // Advance the raster position and accumulate the sample into its tile
  task automatic predict_sample(logic signed [SAMPLE_BITS-1:0] s);
    int unsigned ts, w, h, c, r, tc, tr, bc, br;
    logic [1:0]  sg;
    res_t        exp_res;
    ts = clamp_dim(cfg_tile, MAX_TILE);
    w  = clamp_dim(cfg_width, GridMax);
    h  = clamp_dim(cfg_height, GridMax);
    c  = col_pos;
    r  = row_pos;
    tc = c / ts;
    tr = r / ts;
    bc = c % ts;
    br = r % ts;
    sg = (s > 0) ? SIGN_POS : ((s < 0) ? SIGN_NEG : SIGN_ZERO);

    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end

    // Drop samples outside whole tiles or beyond the tracked columns
    if (c >= w || r >= h || tc >= w / ts || tr >= h / ts || tc >= MAX_TILES_ACROSS) return;

    if (bc == 0 && br == 0) begin
      sign_ref[tc] = sg;
      mix_seen[tc] = 1'b0;
      sum_acc[tc]  = s;
    end else begin
      if (sg != sign_ref[tc]) mix_seen[tc] = 1'b1;
      sum_acc[tc] += s;
    end

    if (bc == ts - 1 && br == ts - 1) begin
      exp_res.tile_row   = tr[CountW-1:0];
      exp_res.tile_col   = tc[ColW-1:0];
      exp_res.tile_class = mix_seen[tc] ? CLASS_MIXED :
                           ((sum_acc[tc] > 0) ? CLASS_POS : CLASS_ZERO);
      tile_results_q = {tile_results_q, exp_res};
    end
  endtask

  // Compare one popped transaction with the oldest expectation
  task automatic compare_result();
    res_t exp_res;
    if (tile_results_q.size() == 0) begin
      log_mismatch($sformatf("result row %0d col %0d class %0d with none expected",
                             tile_row_i, tile_col_i, tile_class_i));
      return;
    end
    exp_res = tile_results_q.pop_front();
    if (tile_row_i !== exp_res.tile_row)
      log_mismatch($sformatf("tile_row got %0d expected %0d",
                             tile_row_i, exp_res.tile_row));
    if (tile_col_i !== exp_res.tile_col)
      log_mismatch($sformatf("tile_col got %0d expected %0d (row %0d)",
                             tile_col_i, exp_res.tile_col, exp_res.tile_row));
    if (tile_class_i !== exp_res.tile_class)
      log_mismatch($sformatf("tile_class got %0d expected %0d (row %0d col %0d)",
                             tile_class_i, exp_res.tile_class,
                             exp_res.tile_row, exp_res.tile_col));
  endtask

  // Track register writes and transactions on both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_tile   = TsW'(8);
      cfg_width  = DimW'(1024);
      cfg_height = DimW'(1024);
      col_pos    = 0;
      row_pos    = 0;
      n_fail     = 0;
      tile_results_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TILE_SIZE:   cfg_tile   = cfg_wdata_i[TsW-1:0];
          REG_GRID_WIDTH:  cfg_width  = cfg_wdata_i;
          REG_GRID_HEIGHT: cfg_height = cfg_wdata_i;
          default: ;
        endcase
      end
      if (push_i && !full_i) predict_sample(sample_i);
      if (pop_i && !empty_i) compare_result();
    end
    fail_count_o <= n_fail;
    pending_o    <= tile_results_q.size();
  end

endmodule

FILE: verif/tile_sign_mix_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_sign_mix_classifier_tb: testbench top of the tile classifier
// Drives raster samples and register settings, pops results with random
// stalls and hands all checking to the checker beside the block.
// ----------------------------------------------------------------------------
module tile_sign_mix_classifier_tb;
  import tsmc_pkg::*;

  localparam int unsigned SettleCycles = 6;
  localparam int          ItemTarget   = 1450;
  localparam int          IdleStop     = 1200;

  typedef enum logic [1:0] {
    POL_POS,
    POL_NEG,
    POL_ZERO,
    POL_ANY
  } polarity_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [IdxW-1:0]       cfg_idx_i;
  logic [DimW-1:0]       cfg_wdata_i;
  logic                  push;
  logic                  full;
  logic signed [31:0]    sample_i;
  logic                  pop;
  logic                  empty;
  logic [CountW-1:0]     tile_row_o;
  logic [ColW-1:0]       tile_col_o;
  logic signed [1:0]     tile_class_o;

  int n_fail;
  int n_pending;
  int n_sent;
  int send_idle_odds;
  bit no_idle;
  bit rx_hold_req;

  logic signed [31:0] extreme_vals [5] = '{32'sh7FFFFFFF, 32'sh80000000, 0, 1, -1};
  logic signed [31:0] corner_grid [15] = '{3, 4, -2, 0, 9,
                                           5, 6, -1, -7, 8,
                                           -1, 2, -3, 4, 0};

  tile_sign_mix_classifier u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .sample_i    (sample_i),
    .pop         (pop),
    .empty       (empty),
    .tile_row_o  (tile_row_o),
    .tile_col_o  (tile_col_o),
    .tile_class_o(tile_class_o)
  );

  tile_sign_mix_classifier_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .full_i      (full),
    .sample_i    (sample_i),
    .pop_i       (pop),
    .empty_i     (empty),
    .tile_row_i  (tile_row_o),
    .tile_col_i  (tile_col_o),
    .tile_class_i(tile_class_o),
    .fail_count_o(n_fail),
    .pending_o   (n_pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Draw one sample of the wanted polarity, with an occasional sign flip
  function automatic logic signed [31:0] draw_sample(polarity_e pol, int flip);
    polarity_e          pick;
    logic signed [31:0] mag;
    pick = pol;
    if (pol == POL_ANY || (flip != 0 && $urandom_range(0, flip) == 0))
      pick = polarity_e'($urandom_range(0, 2));
    case ($urandom_range(0, 3))
      0:       mag = $urandom_range(1, 100);
      1:       mag = $urandom_range(1, 32'h7FFFFFFF);
      2:       mag = 32'sh7FFFFFFF;
      default: mag = $urandom_range(1, 65535);
    endcase
    case (pick)
      POL_POS: return mag;
      POL_NEG: return ($urandom_range(0, 15) == 0) ? 32'sh80000000 : -mag;
      default: return '0;
    endcase
  endfunction

  // Offer one sample and hold it until the block takes it
  task automatic send_sample(logic signed [31:0] v);
    int gap;
    if (!no_idle && send_idle_odds != 0 && $urandom_range(0, send_idle_odds) == 0) begin
      push <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk_i);
    end
    push     <= 1'b1;
    sample_i <= v;
    do @(posedge clk_i); while (full);
    n_sent++;
  endtask

  // Stop offering and wait until every predicted result has been popped
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (n_pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_grid(logic [DimW-1:0] ts, logic [DimW-1:0] w, logic [DimW-1:0] h);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_TILE_SIZE;
    cfg_wdata_i <= ts;
    @(posedge clk_i);
    cfg_idx_i   <= REG_GRID_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= REG_GRID_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Bring the raster position back to the origin with a one-sample grid,
  // then load the new grid and stream n random samples into it
  task automatic run_phase(logic [DimW-1:0] ts, logic [DimW-1:0] w, logic [DimW-1:0] h,
                           int unsigned n, polarity_e pol, int flip);
    settle();
    set_grid(DimW'(1), '0, '0);
    send_sample(draw_sample(POL_ANY, 0));
    settle();
    set_grid(ts, w, h);
    repeat (n) send_sample(draw_sample(pol, flip));
  endtask

  // Receiver: pop in random runs and stalls, with one long hold on request
  initial begin
    pop = 1'b0;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        pop <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned ts, w, h, n;
    polarity_e   pol;
    int          flip;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_TILE_SIZE;
    cfg_wdata_i    = '0;
    push           = 1'b0;
    sample_i       = '0;
    no_idle        = 1'b0;
    rx_hold_req    = 1'b0;
    send_idle_odds = 7;
    n_sent         = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One-sample tiles carrying the sample extremes
    run_phase(DimW'(1), DimW'(5), DimW'(1), 0, POL_ANY, 0);
    foreach (extreme_vals[i]) send_sample(extreme_vals[i]);

    // Two-by-two tiles with a partial right column and bottom row:
    // a positive tile and a mixed tile whose reference sign is negative
    run_phase(DimW'(2), DimW'(5), DimW'(3), 0, POL_ANY, 0);
    foreach (corner_grid[i]) send_sample(corner_grid[i]);

    // Widest grid: tile size 0 acts as 1, columns past the tracked ones drop
    run_phase(DimW'(0), DimW'(32767), DimW'(32767), 270, POL_ANY, 0);

    // Tall grid: one column, every row index, then wrap to row 0
    run_phase(DimW'(1), DimW'(1), DimW'(200), 210, POL_ANY, 0);

    // Oversized tile size clamps to the maximum; no tile completes here
    run_phase(DimW'(127), DimW'(64), DimW'(64), 130, POL_POS, 0);

    // Long receiver hold while the sender keeps offering at full rate
    send_idle_odds = 0;
    run_phase(DimW'(1), DimW'(16), DimW'(16), 0, POL_ANY, 0);
    rx_hold_req = 1'b1;
    repeat (400) send_sample(draw_sample(POL_ANY, 0));

    // Random grids, mostly small tiles; idling stops near the end
    while (n_sent < ItemTarget) begin
      if (n_sent >= IdleStop) no_idle = 1'b1;
      case ($urandom_range(0, 19))
        0:       ts = 0;
        15, 16, 17, 18, 19: ts = $urandom_range(5, 9);
        default: ts = $urandom_range(1, 4);
      endcase
      w = $urandom_range(1, 40);
      h = $urandom_range(1, 16);
      n = ($urandom_range(0, 1) == 0) ? w * h * $urandom_range(1, 2)
                                      : $urandom_range(1, 2 * w * h);
      if (n > ItemTarget - n_sent) n = ItemTarget - n_sent;
      pol  = polarity_e'($urandom_range(0, 3));
      flip = $urandom_range(20, 400);
      case ($urandom_range(0, 2))
        0:       send_idle_odds = 0;
        1:       send_idle_odds = 3;
        default: send_idle_odds = 7;
      endcase
      run_phase(DimW'(ts), DimW'(w), DimW'(h), n, pol, flip);
    end

    settle();
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard limit on the run
  initial begin
    #30ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: tile_sign_mix_classifier.f
rtl/tsmc_pkg.sv
rtl/tsmc_fifo.sv
rtl/tsmc_front.sv
rtl/tsmc_back.sv
rtl/tile_sign_mix_classifier.sv
verif/tile_sign_mix_classifier_checker.sv
verif/tile_sign_mix_classifier_tb.sv
